### rtl/core/tbo_pkg.sv
// Shared widths, types and register codes for the triangle/box overlap test.
`timescale 1ns / 1ps
package tbo_pkg;

	localparam int COORD_BITS = 24;
	localparam int HALF_BITS  = 23;
	localparam int IDX_BITS   = 2;

	localparam int TW   = COORD_BITS + 1;
	localparam int EW   = COORD_BITS + 2;
	localparam int PW   = 2 * EW;
	localparam int NW   = PW + 1;
	localparam int NL   = (NW + 1) / 2;
	localparam int NH   = NW - NL;
	localparam int HSW  = HALF_BITS + 1;
	localparam int PLW  = NL + 1 + TW;
	localparam int PHW  = NH + TW;
	localparam int QLW  = NL + 1 + HSW;
	localparam int QHW  = NH + HSW;
	localparam int DKW  = NW + TW;
	localparam int RKW  = NW + HSW;
	localparam int DW   = DKW + 2;
	localparam int RSW  = RKW + 2;

	localparam int IN_BITS  = 12 * COORD_BITS;
	localparam int IN_BYTES = (IN_BITS + 7) / 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [HALF_BITS-1:0]         half_t;
	typedef logic signed [TW-1:0]         tval_t;
	typedef logic signed [EW-1:0]         edge_t;
	typedef logic signed [PW-1:0]         prod_t;

	typedef enum logic [IDX_BITS-1:0] {
		REG_HALF_X = 2'd0,
		REG_HALF_Y = 2'd1,
		REG_HALF_Z = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

endpackage

### rtl/core/triangle_box_overlap_test_top.sv
// Top level: stream ports, half-extent registers, stage valid/ready control, output register.
`timescale 1ns / 1ps
// Conservative triangle versus axis-aligned box test. One item (three vertices
// and a box center) enters per clock unless held by output stall. Its overlaps
// bit passes seven pipeline stages (edges, interval test and cross products,
// normal, normal products split into two partial halves, combine, sums,
// magnitudes) and then the output register. Each stage advances on its own when
// free, so bubbles close up under output stall. The user must write half extents
// through the cfg port only while no item is in flight; the block does not enforce it.
module triangle_box_overlap_test_top
	import tbo_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// vert_a_x, vert_a_y, vert_a_z, vert_b_x..z, vert_c_x..z, center_x..z
	input  logic [8*IN_BYTES-1:0]   s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// overlaps, zero fill
	output logic [7:0]              m_axis_tdata,
	input  logic                    cfg_wr_en,
	input  logic [IDX_BITS-1:0]     cfg_index,
	input  logic [HALF_BITS-1:0]    cfg_wdata
);

	half_t     half_q [3];
	logic [7:1] vld_q;
	logic       out_vld_q;
	logic       overlaps_q;
	logic [7:1] rdy;
	logic       rdy_out;
	stage_en_t  en;

	coord_t vert_a [3];
	coord_t vert_b [3];
	coord_t vert_c [3];
	coord_t center [3];

	tval_t             t0_s2 [3];
	prod_t             m_s2  [6];
	logic              axis_ok_s2;
	logic [DW-1:0]     dabs_s7;
	logic [RSW-1:0]    rsum_s7;
	logic              axis_ok_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q[0] <= HALF_BITS'(2048);
			half_q[1] <= HALF_BITS'(2048);
			half_q[2] <= HALF_BITS'(2048);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HALF_X: half_q[0] <= cfg_wdata;
				REG_HALF_Y: half_q[1] <= cfg_wdata;
				REG_HALF_Z: half_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vert_a[k] = s_axis_tdata[k*COORD_BITS +: COORD_BITS];
			vert_b[k] = s_axis_tdata[(3+k)*COORD_BITS +: COORD_BITS];
			vert_c[k] = s_axis_tdata[(6+k)*COORD_BITS +: COORD_BITS];
			center[k] = s_axis_tdata[(9+k)*COORD_BITS +: COORD_BITS];
		end
	end

	always_comb begin
		rdy_out = !out_vld_q || m_axis_tready;
		rdy[7]  = !vld_q[7] || rdy_out;
		for (int i = 6; i >= 1; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
		en.s1 = rdy[1];
		en.s2 = rdy[2];
		en.s3 = rdy[3];
		en.s4 = rdy[4];
		en.s5 = rdy[5];
		en.s6 = rdy[6];
		en.s7 = rdy[7];
	end

	assign s_axis_tready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy[1]) vld_q[1] <= s_axis_tvalid;
			for (int i = 2; i <= 7; i++) begin
				if (rdy[i]) vld_q[i] <= vld_q[i-1];
			end
			if (rdy_out) out_vld_q <= vld_q[7];
		end
	end

	tbo_front u_front (
		.clk        (clk),
		.en         (en),
		.vert_a     (vert_a),
		.vert_b     (vert_b),
		.vert_c     (vert_c),
		.center     (center),
		.half       (half_q),
		.t0_s2      (t0_s2),
		.m_s2       (m_s2),
		.axis_ok_s2 (axis_ok_s2)
	);

	tbo_plane u_plane (
		.clk        (clk),
		.en         (en),
		.t0_s2      (t0_s2),
		.m_s2       (m_s2),
		.axis_ok_s2 (axis_ok_s2),
		.half       (half_q),
		.dabs_s7    (dabs_s7),
		.rsum_s7    (rsum_s7),
		.axis_ok_s7 (axis_ok_s7)
	);

	always_ff @(posedge clk) begin
		if (rdy_out) overlaps_q <= axis_ok_s7 && !(dabs_s7 > DW'(rsum_s7));
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'b0, overlaps_q};

endmodule

### rtl/core/tbo_front.sv
// Front stages: box-centered vertices, edges, per-axis interval test, cross products.
`timescale 1ns / 1ps
module tbo_front
	import tbo_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  coord_t    vert_a [3],
	input  coord_t    vert_b [3],
	input  coord_t    vert_c [3],
	input  coord_t    center [3],
	input  half_t     half   [3],
	output tval_t     t0_s2  [3],
	output prod_t     m_s2   [6],
	output logic      axis_ok_s2
);

	tval_t t_s1  [3][3];
	edge_t e0_s1 [3];
	edge_t e1_s1 [3];

	tval_t t_c  [3][3];
	edge_t e0_c [3];
	edge_t e1_c [3];
	logic  [2:0] rej_c;
	prod_t m_c  [6];

	always_comb begin
		tval_t va, vb, vc, cc;
		edge_t ea, eb, ec;
		for (int k = 0; k < 3; k++) begin
			va = vert_a[k];
			vb = vert_b[k];
			vc = vert_c[k];
			cc = center[k];
			t_c[0][k] = va - cc;
			t_c[1][k] = vb - cc;
			t_c[2][k] = vc - cc;
			ea = vert_a[k];
			eb = vert_b[k];
			ec = vert_c[k];
			e0_c[k] = eb - ea;
			e1_c[k] = ec - eb;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			t_s1  <= t_c;
			e0_s1 <= e0_c;
			e1_s1 <= e1_c;
		end
	end

	always_comb begin
		tval_t lo, hi, hs;
		for (int k = 0; k < 3; k++) begin
			lo = t_s1[0][k];
			hi = t_s1[0][k];
			if (t_s1[1][k] < lo) lo = t_s1[1][k];
			if (t_s1[2][k] < lo) lo = t_s1[2][k];
			if (t_s1[1][k] > hi) hi = t_s1[1][k];
			if (t_s1[2][k] > hi) hi = t_s1[2][k];
			hs = $signed({2'b00, half[k]});
			rej_c[k] = (hs < lo) || (hi < -hs);
		end
		m_c[0] = e0_s1[1] * e1_s1[2];
		m_c[1] = e0_s1[2] * e1_s1[1];
		m_c[2] = e0_s1[2] * e1_s1[0];
		m_c[3] = e0_s1[0] * e1_s1[2];
		m_c[4] = e0_s1[0] * e1_s1[1];
		m_c[5] = e0_s1[1] * e1_s1[0];
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			t0_s2      <= t_s1[0];
			m_s2       <= m_c;
			axis_ok_s2 <= ~|rej_c;
		end
	end

endmodule

### rtl/core/tbo_plane.sv
// Plane stages: normal, split products n*t0 and n*h, sums and magnitudes.
`timescale 1ns / 1ps
module tbo_plane
	import tbo_pkg::*;
(
	input  logic            clk,
	input  stage_en_t       en,
	input  tval_t           t0_s2 [3],
	input  prod_t           m_s2  [6],
	input  logic            axis_ok_s2,
	input  half_t           half  [3],
	output logic [DW-1:0]   dabs_s7,
	output logic [RSW-1:0]  rsum_s7,
	output logic            axis_ok_s7
);

	logic signed [NW-1:0]  n_s3  [3];
	tval_t                 t0_s3 [3];
	logic                  ok_s3;

	logic signed [PLW-1:0] pl_s4 [3];
	logic signed [PHW-1:0] ph_s4 [3];
	logic signed [QLW-1:0] ql_s4 [3];
	logic signed [QHW-1:0] qh_s4 [3];
	logic                  ok_s4;

	logic signed [DKW-1:0] dk_s5 [3];
	logic signed [RKW-1:0] rk_s5 [3];
	logic                  ok_s5;

	logic signed [DW-1:0]  d_s6;
	logic [RKW-1:0]        ra_s6 [3];
	logic                  ok_s6;

	logic signed [NW-1:0]  n_c  [3];
	logic signed [PLW-1:0] pl_c [3];
	logic signed [PHW-1:0] ph_c [3];
	logic signed [QLW-1:0] ql_c [3];
	logic signed [QHW-1:0] qh_c [3];
	logic signed [DKW-1:0] dk_c [3];
	logic signed [RKW-1:0] rk_c [3];
	logic signed [DW-1:0]  d_c;
	logic [RKW-1:0]        ra_c [3];
	logic [DW-1:0]         dabs_c;
	logic [RSW-1:0]        rsum_c;

	always_comb begin
		logic signed [NW-1:0] a, b;
		for (int k = 0; k < 3; k++) begin
			a = m_s2[2*k];
			b = m_s2[2*k+1];
			n_c[k] = a - b;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			n_s3  <= n_c;
			t0_s3 <= t0_s2;
			ok_s3 <= axis_ok_s2;
		end
	end

	always_comb begin
		logic signed [NL:0]    nl;
		logic signed [NH-1:0]  nh;
		logic signed [HSW-1:0] hs;
		for (int k = 0; k < 3; k++) begin
			nl = $signed({1'b0, n_s3[k][NL-1:0]});
			nh = $signed(n_s3[k][NW-1:NL]);
			hs = $signed({1'b0, half[k]});
			pl_c[k] = nl * t0_s3[k];
			ph_c[k] = nh * t0_s3[k];
			ql_c[k] = nl * hs;
			qh_c[k] = nh * hs;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pl_s4 <= pl_c;
			ph_s4 <= ph_c;
			ql_s4 <= ql_c;
			qh_s4 <= qh_c;
			ok_s4 <= ok_s3;
		end
	end

	always_comb begin
		logic signed [DKW-1:0] dh, dl;
		logic signed [RKW-1:0] rh, rl;
		for (int k = 0; k < 3; k++) begin
			dh = ph_s4[k];
			dl = pl_s4[k];
			rh = qh_s4[k];
			rl = ql_s4[k];
			dk_c[k] = (dh <<< NL) + dl;
			rk_c[k] = (rh <<< NL) + rl;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			dk_s5 <= dk_c;
			rk_s5 <= rk_c;
			ok_s5 <= ok_s4;
		end
	end

	always_comb begin
		logic signed [DW-1:0] x0, x1, x2;
		x0 = dk_s5[0];
		x1 = dk_s5[1];
		x2 = dk_s5[2];
		d_c = x0 + x1 + x2;
		for (int k = 0; k < 3; k++) begin
			ra_c[k] = rk_s5[k][RKW-1] ? RKW'(-rk_s5[k]) : RKW'(rk_s5[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			d_s6  <= d_c;
			ra_s6 <= ra_c;
			ok_s6 <= ok_s5;
		end
	end

	always_comb begin
		dabs_c = d_s6[DW-1] ? DW'(-d_s6) : DW'(d_s6);
		rsum_c = RSW'(ra_s6[0]) + RSW'(ra_s6[1]) + RSW'(ra_s6[2]);
	end

	always_ff @(posedge clk) begin
		if (en.s7) begin
			dabs_s7    <= dabs_c;
			rsum_s7    <= rsum_c;
			axis_ok_s7 <= ok_s6;
		end
	end

endmodule

### tb/tb_top.sv
// Self-checking bench for the triangle/box overlap block: stream driver, result monitor, checks.
`timescale 1ns / 1ps
module tb_top;
	import tbo_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam logic [IDX_BITS-1:0] REG_NONE = 2'd3;

	typedef coord_t [11:0] tri_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [8*IN_BYTES-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic cfg_wr_en = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = REG_HALF_X;
	logic [HALF_BITS-1:0] cfg_wdata = '0;

	tri_item_t tri_pending_q[$];
	bit overlap_expect_q[$];
	half_t half_cfg[3] = '{23'd2048, 23'd2048, 23'd2048};
	int fail_cnt = 0;
	int cycle_cnt = 0;
	int snd_idle_pct = 25;
	int rcv_idle_pct = 25;
	bit stall_go = 1'b0;
	bit stall_done = 1'b0;
	int stall_left = 0;
	logic in_taken = 1'b0;

	triangle_box_overlap_test_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// axis interval tests, then plane distance against projected box radius
	function automatic bit predict_overlap(tri_item_t it);
		longint t[3][3];
		longint mn, mx, hk;
		logic signed [127:0] e0[3], e1[3], nv[3], t0[3], hw[3];
		logic signed [127:0] d, r;
		bit hit;
		int v, k;
		hit = 1'b1;
		for (v = 0; v < 3; v++)
			for (k = 0; k < 3; k++)
				t[v][k] = longint'($signed(it[v*3+k])) - longint'($signed(it[9+k]));
		for (k = 0; k < 3; k++) begin
			hk = longint'(half_cfg[k]);
			mn = t[0][k];
			mx = t[0][k];
			for (v = 1; v < 3; v++) begin
				if (t[v][k] < mn) mn = t[v][k];
				if (t[v][k] > mx) mx = t[v][k];
			end
			if (hk < mn || mx < -hk) hit = 1'b0;
		end
		if (hit) begin
			for (k = 0; k < 3; k++) begin
				e0[k] = t[1][k] - t[0][k];
				e1[k] = t[2][k] - t[1][k];
				t0[k] = t[0][k];
				hw[k] = half_cfg[k];
			end
			nv[0] = e0[1] * e1[2] - e0[2] * e1[1];
			nv[1] = e0[2] * e1[0] - e0[0] * e1[2];
			nv[2] = e0[0] * e1[1] - e0[1] * e1[0];
			d = 0;
			r = 0;
			for (k = 0; k < 3; k++) begin
				d = d + nv[k] * t0[k];
				r = r + ((nv[k] < 0) ? -nv[k] : nv[k]) * hw[k];
			end
			if (((d < 0) ? -d : d) > r) hit = 1'b0;
		end
		return hit;
	endfunction

	function automatic tri_item_t pack_tri(longint f[12]);
		tri_item_t it;
		for (int i = 0; i < 12; i++) it[i] = coord_t'(f[i]);
		return it;
	endfunction

	function automatic longint rand_off(longint span);
		return longint'($urandom_range(32'(2 * span))) - span;
	endfunction

	// vertices scattered around a random center, spread relative to the box
	function automatic tri_item_t make_near();
		longint f[12];
		longint span;
		int mult;
		mult = $urandom_range(3);
		for (int k = 0; k < 3; k++) f[9+k] = $signed(coord_t'($urandom));
		for (int k = 0; k < 3; k++) begin
			span = longint'(half_cfg[k]) * mult + $urandom_range(1, 64);
			for (int v = 0; v < 3; v++) f[v*3+k] = f[9+k] + rand_off(span);
		end
		return pack_tri(f);
	endfunction

	// collinear or coincident vertices
	function automatic tri_item_t make_degenerate();
		longint f[12];
		longint step;
		for (int k = 0; k < 3; k++) begin
			f[9+k] = $signed(coord_t'($urandom));
			step = ($urandom_range(3) == 0) ? 0 : rand_off(longint'(half_cfg[k]) + 16);
			f[k] = f[9+k] + rand_off(2 * longint'(half_cfg[k]) + 16);
			f[3+k] = f[k] + step;
			f[6+k] = f[k] + 2 * step;
		end
		return pack_tri(f);
	endfunction

	// flat triangle lying on a box face, or just beyond it
	function automatic tri_item_t make_touching(int ax, bit neg, int bump);
		longint f[12];
		longint pos;
		for (int k = 0; k < 3; k++) begin
			f[9+k] = $signed(coord_t'($urandom_range(0, 4000000)));
			for (int v = 0; v < 3; v++) begin
				if (k == ax) begin
					pos = longint'(half_cfg[k]) + bump;
					f[v*3+k] = f[9+k] + (neg ? -pos : pos);
				end else begin
					f[v*3+k] = f[9+k] + rand_off(longint'(half_cfg[k]));
				end
			end
		end
		return pack_tri(f);
	endfunction

	// triangle across the three axes, plane distance near the box radius
	function automatic tri_item_t make_slanted();
		longint f[12];
		longint a;
		for (int i = 0; i < 12; i++) f[i] = 0;
		for (int k = 0; k < 3; k++) f[9+k] = $signed(coord_t'($urandom_range(0, 4000000)));
		for (int k = 0; k < 3; k++) begin
			a = (longint'(half_cfg[k]) * $urandom_range(2, 14)) / 4 + $urandom_range(1, 8);
			for (int v = 0; v < 3; v++) f[v*3+k] = f[9+k];
			f[k*3+k] = f[9+k] + (($urandom_range(1) != 0) ? -a : a);
		end
		return pack_tri(f);
	endfunction

	function automatic tri_item_t make_noise();
		tri_item_t it;
		for (int i = 0; i < 12; i++) it[i] = coord_t'($urandom);
		return it;
	endfunction

	function automatic tri_item_t make_random_item();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) return make_near();
		if (sel < 67) return make_degenerate();
		if (sel < 77) return make_touching($urandom_range(2), 1'($urandom_range(1)),
			$urandom_range(1));
		if (sel < 87) return make_slanted();
		return make_noise();
	endfunction

	task automatic write_half(logic [IDX_BITS-1:0] idx, half_t val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_HALF_X: half_cfg[0] = val;
			REG_HALF_Y: half_cfg[1] = val;
			REG_HALF_Z: half_cfg[2] = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (tri_pending_q.size() != 0 || s_axis_tvalid || overlap_expect_q.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) tri_pending_q.push_back(make_random_item());
	endtask

	// sender: hold the item until taken, otherwise maybe idle
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (tri_pending_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				s_axis_tdata <= tri_pending_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random backpressure plus one long hold-off
	always @(negedge clk) begin
		if (stall_go && !stall_done) begin
			stall_left = 300;
			stall_done = 1'b1;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		logic [7:0] want;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				overlap_expect_q.push_back(predict_overlap(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (overlap_expect_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h", $time, m_axis_tdata);
					fail_cnt++;
				end else begin
					want = {7'b0, overlap_expect_q.pop_front()};
					if (m_axis_tdata !== want) begin
						$display("%0t: overlaps mismatch, expected %h, actual %h",
							$time, want, m_axis_tdata);
						fail_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset extents (0.5): extremes, touching faces, plane cases, degenerates
		tri_pending_q.push_back(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{12{longint'(8388607)}}));
		tri_pending_q.push_back(pack_tri('{12{longint'(-8388608)}}));
		tri_pending_q.push_back(pack_tri('{8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, -8388608, -8388608, -8388608}));
		tri_pending_q.push_back(pack_tri('{-8388608, -8388608, -8388608, -8388608, -8388608,
			-8388608, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607}));
		tri_pending_q.push_back(pack_tri('{-8388608, 0, 8388607, 8388607, -8388608, 0,
			0, 8388607, -8388608, 0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{6144, 0, 0, 0, 6144, 0, 0, 0, 6144, 0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{6145, 0, 0, 0, 6145, 0, 0, 0, 6145, 0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{-6145, 0, 0, 0, -6145, 0, 0, 0, -6145, 0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{2048, -2048, 0, 2048, 2048, 0, 2048, 0, 2048,
			0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{2049, -2048, 0, 2049, 2048, 0, 2049, 0, 2048,
			0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{-3000, -3000, -3000, 0, 0, 0, 3000, 3000, 3000,
			0, 0, 0}));
		tri_pending_q.push_back(pack_tri('{5000, 5000, 5000, 5000, 5000, 5000, 5000, 5000, 5000,
			0, 0, 0}));
		tri_pending_q.push_back(make_touching(0, 1'b0, 0));
		tri_pending_q.push_back(make_touching(1, 1'b1, 0));
		tri_pending_q.push_back(make_touching(2, 1'b0, 1));
		tri_pending_q.push_back(make_touching(0, 1'b1, 1));
		tri_pending_q.push_back(make_degenerate());
		tri_pending_q.push_back(make_slanted());
		queue_random(200);
		wait_drained();

		// zero extents: the box is a point
		write_half(REG_HALF_X, '0);
		write_half(REG_HALF_Y, '0);
		write_half(REG_HALF_Z, '0);
		tri_pending_q.push_back(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
		tri_pending_q.push_back(make_touching(1, 1'b0, 0));
		queue_random(120);
		wait_drained();

		// largest extents, no idling on either side
		write_half(REG_HALF_X, 23'h7FFFFF);
		write_half(REG_HALF_Y, 23'h7FFFFF);
		write_half(REG_HALF_Z, 23'h7FFFFF);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		tri_pending_q.push_back(pack_tri('{8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, -8388608, -8388608, -8388608}));
		queue_random(150);
		wait_drained();
		snd_idle_pct = 25;
		rcv_idle_pct = 25;

		// random extents, unused register index, long output hold-off
		write_half(REG_HALF_X, half_t'($urandom_range(0, 8388607)));
		write_half(REG_HALF_Y, half_t'($urandom_range(0, 8388607)));
		write_half(REG_HALF_Z, half_t'($urandom_range(0, 8388607)));
		write_half(REG_NONE, half_t'($urandom_range(0, 8388607)));
		queue_random(230);
		stall_go = 1'b1;
		wait_drained();

		// mixed extents
		write_half(REG_HALF_X, 23'd1);
		write_half(REG_HALF_Y, 23'h7FFFFF);
		write_half(REG_HALF_Z, 23'd4096);
		queue_random(200);
		wait_drained();

		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/tbo_pkg.sv
rtl/core/tbo_front.sv
rtl/core/tbo_plane.sv
rtl/core/triangle_box_overlap_test_top.sv
tb/tb_top.sv
